// ===== hdl/csx_pkg.sv =====
// Shared types, widths and constants for the CAN signal extract and scale block.
package csx_pkg;

   localparam int FRAME_BYTES_DEF = 8;

   localparam int BYTE_W    = 8;
   localparam int FRAME_W   = 64;
   localparam int START_W   = 6;
   localparam int LEN_W     = 6;
   localparam int RAW_W     = 32;
   localparam int FACTOR_W  = 32;
   localparam int Q_W       = 48;
   localparam int VALUE_W   = RAW_W + 1;
   localparam int PROD_W    = VALUE_W + FACTOR_W;
   localparam int SUM_W     = 64;
   localparam int WIN_BYTES = 5;
   localparam int WIN_W     = WIN_BYTES * BYTE_W;
   localparam int PAD_W     = 4 * BYTE_W;
   localparam int PADDED_W  = FRAME_W + 2 * PAD_W;
   localparam int PIDX_W    = $clog2(PADDED_W);

   localparam logic signed [PROD_W-1:0] PROD_CAP   = PROD_W'(64'sh4000_0000_0000_0000);
   localparam logic signed [PROD_W-1:0] PROD_FLOOR = -PROD_CAP;
   localparam logic signed [SUM_W-1:0]  SUM_MAX    = SUM_W'(64'sh0000_7FFF_FFFF_FFFF);
   localparam logic signed [SUM_W-1:0]  SUM_MIN    = -SUM_MAX - SUM_W'(64'sd1);
   localparam logic signed [Q_W-1:0]    Q_MAX      = Q_W'(SUM_MAX);
   localparam logic signed [Q_W-1:0]    Q_MIN      = Q_W'(SUM_MIN);

   typedef struct packed {
      logic [FRAME_W-1:0]         frame;
      logic [START_W-1:0]         start_bit;
      logic [LEN_W-1:0]           bit_length;
      logic                       big_endian;
      logic                       is_signed;
      logic signed [FACTOR_W-1:0] factor;
      logic signed [Q_W-1:0]      offset;
      logic signed [Q_W-1:0]      min_limit;
      logic signed [Q_W-1:0]      max_limit;
   } csx_req_type;

   typedef struct packed {
      logic [RAW_W-1:0]      raw_value;
      logic signed [Q_W-1:0] physical_value;
      logic                  saturated;
   } csx_rsp_type;

   // Beat leaving the extract stage toward the scaler.
   typedef struct packed {
      logic                       valid;
      logic [RAW_W-1:0]           raw;
      logic signed [VALUE_W-1:0]  value;
      logic signed [FACTOR_W-1:0] factor;
      logic signed [Q_W-1:0]      offset;
      logic signed [Q_W-1:0]      min_limit;
      logic signed [Q_W-1:0]      max_limit;
   } csx_ext_type;

endpackage

// ===== hdl/can_signal_extract_scale.sv =====
// Top level of the CAN signal extract and scale block.
//
//   channel   ports                    direction  beat taken when
//   request   start, busy, req_item    in         start && !busy at a rising edge
//   response  rsp_valid, rsp_item      out        rsp_valid at a rising edge
//
// A beat can be accepted every cycle; busy stays low, since every stage advances
// each cycle and nothing can back up.
// A result passes the input register, extract register, product register (the 33x32 multiplier),
// sum register and result register before it is taken.
// Each result is shown for one cycle only; the receiver cannot stall it.
// Reset clears the valid bits of all stages and drops any beats in flight.
module can_signal_extract_scale #(
   parameter int FRAME_BYTES = csx_pkg::FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  csx_pkg::csx_req_type req_item,
   output logic                 rsp_valid,
   output csx_pkg::csx_rsp_type rsp_item
);
   import csx_pkg::*;

   logic        accept;
   logic        in_valid_ff;
   csx_req_type req_ff;
   csx_ext_type ext;

   // No stage ever holds, so the request side is always open.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Capture the request beat; payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
   end

   // Gather the byte window and cut out the raw signal bits.
   csx_extract #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_extract (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_item  (req_ff),
      .ext      (ext)
   );

   // Scale to Q32.16, saturate, then clamp to the limits.
   csx_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .ext       (ext),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== hdl/csx_extract.sv =====
// Bit extraction stage: byte window, shift, length mask and sign extension.
module csx_extract #(
   parameter int FRAME_BYTES = csx_pkg::FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  csx_pkg::csx_req_type in_item,
   output csx_pkg::csx_ext_type ext
);
   import csx_pkg::*;

   logic [FRAME_W-1:0]        frame_m;
   logic [PADDED_W-1:0]       padded;
   logic [2:0]                base;
   logic [2:0]                shift;
   logic [PIDX_W-1:0]         intel_idx;
   logic [PIDX_W-1:0]         moto_idx;
   logic [WIN_W-1:0]          intel_win;
   logic [WIN_W-1:0]          moto_src;
   logic [WIN_W-1:0]          moto_win;
   logic [WIN_W-1:0]          win;
   logic [WIN_W-1:0]          shifted;
   logic [LEN_W-1:0]          len_c;
   logic [LEN_W-1:0]          mask_sh;
   logic [4:0]                top_bit;
   logic [RAW_W-1:0]          mask;
   logic [RAW_W-1:0]          masked;
   logic [RAW_W-1:0]          raw_in;
   logic signed [VALUE_W-1:0] value_in;

   logic                      valid_ff;
   logic [RAW_W-1:0]          raw_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [FACTOR_W-1:0] factor_ff;
   logic signed [Q_W-1:0]     offset_ff;
   logic signed [Q_W-1:0]     min_ff;
   logic signed [Q_W-1:0]     max_ff;

   always_comb begin
      // Bytes past the frame length read as zero.
      for (int i = 0; i < FRAME_W / BYTE_W; i++) begin
         if (i < FRAME_BYTES) begin
            frame_m[i*BYTE_W +: BYTE_W] = in_item.frame[i*BYTE_W +: BYTE_W];
         end else begin
            frame_m[i*BYTE_W +: BYTE_W] = '0;
         end
      end
      // Four zero bytes on each side cover indexes below zero and above seven.
      padded    = {{PAD_W{1'b0}}, frame_m, {PAD_W{1'b0}}};
      base      = in_item.start_bit[START_W-1:3];
      shift     = in_item.start_bit[2:0];
      intel_idx = PIDX_W'({base, 3'b000}) + PIDX_W'(PAD_W);
      moto_idx  = PIDX_W'({base, 3'b000});
      intel_win = padded[intel_idx +: WIN_W];
      moto_src  = padded[moto_idx +: WIN_W];
      for (int k = 0; k < WIN_BYTES; k++) begin
         moto_win[k*BYTE_W +: BYTE_W] = moto_src[(WIN_BYTES-1-k)*BYTE_W +: BYTE_W];
      end
      win     = in_item.big_endian ? moto_win : intel_win;
      shifted = win >> shift;

      if (in_item.bit_length == '0) begin
         len_c = LEN_W'(1);
      end else if (in_item.bit_length > LEN_W'(RAW_W)) begin
         len_c = LEN_W'(RAW_W);
      end else begin
         len_c = in_item.bit_length;
      end
      mask_sh = LEN_W'(RAW_W) - len_c;
      top_bit = 5'(len_c - LEN_W'(1));
      mask    = {RAW_W{1'b1}} >> mask_sh;
      masked  = shifted[RAW_W-1:0] & mask;
      if (in_item.is_signed && masked[top_bit]) begin
         raw_in = masked | ~mask;
      end else begin
         raw_in = masked;
      end
      value_in = $signed({in_item.is_signed & raw_in[RAW_W-1], raw_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff    <= raw_in;
      value_ff  <= value_in;
      factor_ff <= in_item.factor;
      offset_ff <= in_item.offset;
      min_ff    <= in_item.min_limit;
      max_ff    <= in_item.max_limit;
   end

   assign ext = '{valid:     valid_ff,
                  raw:       raw_ff,
                  value:     value_ff,
                  factor:    factor_ff,
                  offset:    offset_ff,
                  min_limit: min_ff,
                  max_limit: max_ff};

endmodule

// ===== hdl/csx_scale.sv =====
// Scaling stages: multiply, cap and add offset, then saturate and clamp.
module csx_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  csx_pkg::csx_ext_type ext,
   output logic                 rsp_valid,
   output csx_pkg::csx_rsp_type rsp_item
);
   import csx_pkg::*;

   // Multiply stage
   logic                       p_valid_ff;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [RAW_W-1:0]           p_raw_ff;
   logic signed [Q_W-1:0]      p_offset_ff;
   logic signed [Q_W-1:0]      p_min_ff;
   logic signed [Q_W-1:0]      p_max_ff;

   // Add stage
   logic                       s_valid_ff;
   logic signed [PROD_W-1:0]   capped;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [RAW_W-1:0]           s_raw_ff;
   logic signed [Q_W-1:0]      s_min_ff;
   logic signed [Q_W-1:0]      s_max_ff;

   // Result stage
   logic                       o_valid_ff;
   logic signed [Q_W-1:0]      sat_val;
   logic                       sat_in;
   logic signed [Q_W-1:0]      phys_in;
   csx_rsp_type                rsp_ff;

   assign prod_in = PROD_W'(ext.value) * PROD_W'(ext.factor);

   always_comb begin
      if (prod_ff > PROD_CAP) begin
         capped = PROD_CAP;
      end else if (prod_ff < PROD_FLOOR) begin
         capped = PROD_FLOOR;
      end else begin
         capped = prod_ff;
      end
      sum_in = SUM_W'(capped) + SUM_W'(p_offset_ff);
   end

   always_comb begin
      if (sum_ff > SUM_MAX) begin
         sat_val = Q_MAX;
         sat_in  = 1'b1;
      end else if (sum_ff < SUM_MIN) begin
         sat_val = Q_MIN;
         sat_in  = 1'b1;
      end else begin
         sat_val = Q_W'(sum_ff);
         sat_in  = 1'b0;
      end
      phys_in = sat_val;
      // Both limits zero disables the clamp; upper bound first, then lower.
      if (s_min_ff != '0 || s_max_ff != '0) begin
         if (phys_in > s_max_ff) begin
            phys_in = s_max_ff;
         end
         if (s_min_ff > phys_in) begin
            phys_in = s_min_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= ext.valid;
         s_valid_ff <= p_valid_ff;
         o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      p_raw_ff    <= ext.raw;
      p_offset_ff <= ext.offset;
      p_min_ff    <= ext.min_limit;
      p_max_ff    <= ext.max_limit;
      sum_ff      <= sum_in;
      s_raw_ff    <= p_raw_ff;
      s_min_ff    <= p_min_ff;
      s_max_ff    <= p_max_ff;
      rsp_ff      <= '{raw_value: s_raw_ff, physical_value: phys_in, saturated: sat_in};
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== hdl/csx_checker.sv =====
// Port-level checks for the CAN signal extract and scale block, bound to the top level.
module csx_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input csx_pkg::csx_req_type req_item,
   input logic                 rsp_valid,
   input csx_pkg::csx_rsp_type rsp_item
);
   import csx_pkg::*;

   // Every accepted beat yields a result.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted beat produced no result");

   // No result without a matching request beat.
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result without request beat");

   // Unsigned signals leave no bits above their length.
   a_unsigned_width : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(req_item.is_signed, 5)
       && $past(req_item.bit_length, 5) >= LEN_W'(1)
       && $past(req_item.bit_length, 5) <= LEN_W'(RAW_W))
      |-> (({32'b0, rsp_item.raw_value} >> $past(req_item.bit_length, 5)) == 64'b0))
      else $error("unsigned raw value exceeds its length");

   // With clamping off, a saturated result sits on a range limit.
   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.saturated
       && $past(req_item.min_limit, 5) == '0 && $past(req_item.max_limit, 5) == '0)
      |-> (rsp_item.physical_value == Q_MAX || rsp_item.physical_value == Q_MIN))
      else $error("saturated result off the range limits");

endmodule

bind can_signal_extract_scale csx_checker u_csx_checker (.*);
